FILE: src/aov_pkg.sv
`timescale 1ns / 1ps

package aov_pkg;

  // default values of the top level parameters
  localparam int SINE_DEPTH_DEF = 256;
  localparam int TIME_BITS_DEF  = 21;

  // field widths
  localparam int LEN_W    = 20;
  localparam int LVL_W    = 16;
  localparam int CFG_W    = 20;
  localparam int REG_IDX_W = 3;

  // datapath widths: three chained products, 5000 * gain * env * |wave|
  localparam int MAG_W    = 61;
  localparam int MUL_B_W  = 16;
  localparam int MUL_A_W  = MAG_W - MUL_B_W;
  localparam int MAG_SHIFT = 38;
  localparam int DIVD_W   = LVL_W + LEN_W;

  // serial divider: quotient never exceeds full scale, so 16 bits suffice
  localparam int DIV_STEPS = 16;
  typedef logic [$clog2(DIV_STEPS)-1:0] dcnt_t;
  localparam dcnt_t DIV_LAST = dcnt_t'(DIV_STEPS - 1);

  localparam logic [MUL_A_W-1:0] OUT_GAIN   = MUL_A_W'(5000);
  localparam logic [LVL_W-1:0]   FULL_Q15   = 16'h8000;
  localparam logic [31:0]        LFSR_MASK  = 32'h8020_0003;
  localparam logic [31:0]        LFSR_SEED  = 32'h0000_0001;
  localparam logic [15:0]        GAIN_RESET = 16'd256;
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

  // request codes
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_KEY_ON  = 2'd1;
  localparam logic [1:0] REQ_KEY_OFF = 2'd2;

  // wave codes
  localparam logic [2:0] WAVE_SILENCE = 3'd0;
  localparam logic [2:0] WAVE_SINE    = 3'd1;
  localparam logic [2:0] WAVE_SQUARE  = 3'd2;
  localparam logic [2:0] WAVE_TRI     = 3'd3;
  localparam logic [2:0] WAVE_SAW     = 3'd4;
  localparam logic [2:0] WAVE_NOISE   = 3'd5;

  // gate modes
  localparam logic [1:0] GATE_IDLE     = 2'd0;
  localparam logic [1:0] GATE_HELD     = 2'd1;
  localparam logic [1:0] GATE_RELEASED = 2'd2;

  // envelope segment that needs the divider
  localparam logic [1:0] DV_NONE    = 2'd0;
  localparam logic [1:0] DV_ATTACK  = 2'd1;
  localparam logic [1:0] DV_DECAY   = 2'd2;
  localparam logic [1:0] DV_RELEASE = 2'd3;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_WAVE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DECAY   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] phase_step;
    logic [15:0] note_gain;
    logic        gain_valid;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               note_active;
  } out_t;

  typedef struct packed {
    logic [2:0]       wave_select;
    logic [LEN_W-1:0] attack_len;
    logic [LEN_W-1:0] decay_len;
    logic [LVL_W-1:0] sustain_level;
    logic [LEN_W-1:0] release_len;
  } cfg_t;

  typedef struct packed {
    logic gate_idle;
    logic no_div;
  } stat_t;

  // microcode
  typedef logic [3:0] op_t;
  typedef logic [3:0] pc_t;
  typedef logic [1:0] cond_t;

  localparam op_t OP_NOP     = 4'd0;
  localparam op_t OP_ENV     = 4'd1;
  localparam op_t OP_DLOAD   = 4'd2;
  localparam op_t OP_DSTEP   = 4'd3;
  localparam op_t OP_DFIN    = 4'd4;
  localparam op_t OP_GAIN    = 4'd5;
  localparam op_t OP_MENV    = 4'd6;
  localparam op_t OP_WAVE    = 4'd7;
  localparam op_t OP_MWAVE   = 4'd8;
  localparam op_t OP_FINISH  = 4'd9;
  localparam op_t OP_IDLEOUT = 4'd10;

  localparam cond_t COND_NEVER = 2'd0;
  localparam cond_t COND_IDLE  = 2'd1;
  localparam cond_t COND_NODIV = 2'd2;
  localparam cond_t COND_LOOP  = 2'd3;

  localparam pc_t S_ENV   = 4'd0;
  localparam pc_t S_DLOAD = 4'd1;
  localparam pc_t S_DSTEP = 4'd2;
  localparam pc_t S_DFIN  = 4'd3;
  localparam pc_t S_GAIN  = 4'd4;
  localparam pc_t S_MENV  = 4'd5;
  localparam pc_t S_WAVE  = 4'd6;
  localparam pc_t S_MWAVE = 4'd7;
  localparam pc_t S_FIN   = 4'd8;
  localparam pc_t S_IDLE  = 4'd9;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  last;
  } uword_t;

  function automatic uword_t prog_word(input pc_t pc);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_NEVER, target: S_ENV, last: 1'b1};
    case (pc)
      S_ENV:   w = '{op: OP_ENV,     cond: COND_IDLE,  target: S_IDLE,  last: 1'b0};
      S_DLOAD: w = '{op: OP_DLOAD,   cond: COND_NODIV, target: S_GAIN,  last: 1'b0};
      S_DSTEP: w = '{op: OP_DSTEP,   cond: COND_LOOP,  target: S_DSTEP, last: 1'b0};
      S_DFIN:  w = '{op: OP_DFIN,    cond: COND_NEVER, target: S_ENV,   last: 1'b0};
      S_GAIN:  w = '{op: OP_GAIN,    cond: COND_NEVER, target: S_ENV,   last: 1'b0};
      S_MENV:  w = '{op: OP_MENV,    cond: COND_NEVER, target: S_ENV,   last: 1'b0};
      S_WAVE:  w = '{op: OP_WAVE,    cond: COND_NEVER, target: S_ENV,   last: 1'b0};
      S_MWAVE: w = '{op: OP_MWAVE,   cond: COND_NEVER, target: S_ENV,   last: 1'b0};
      S_FIN:   w = '{op: OP_FINISH,  cond: COND_NEVER, target: S_ENV,   last: 1'b1};
      S_IDLE:  w = '{op: OP_IDLEOUT, cond: COND_NEVER, target: S_ENV,   last: 1'b1};
      default: w = '{op: OP_NOP,     cond: COND_NEVER, target: S_ENV,   last: 1'b1};
    endcase
    return w;
  endfunction

  // quarter sine in Q15 from an angle in Q30, taylor series to x^13
  function automatic logic [15:0] sine_poly(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    r = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return r[15:0];
  endfunction

endpackage

FILE: src/aov_sine.sv
`timescale 1ns / 1ps

module aov_sine #(
  parameter int SINE_TABLE_DEPTH = aov_pkg::SINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic [31:0] phase,
  output logic [15:0] data
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = 30 + IW;
  localparam logic [IW-1:0] DEPTH_V = IW'(SINE_TABLE_DEPTH);

  logic [PW-1:0] iprod;
  logic [IW-1:0] idx_raw;
  logic [IW-1:0] idx_c;
  logic [IW-1:0] idx_r;
  logic [15:0]   data_r;
  logic [15:0]   rom_w [SINE_TABLE_DEPTH+1];

  // position inside the quadrant, scaled to table entries
  assign iprod   = PW'(phase[29:0]) * PW'(DEPTH_V);
  assign idx_raw = iprod[PW-1:30];
  // odd quadrants run the table backwards
  assign idx_c   = phase[30] ? (DEPTH_V - idx_raw) : idx_raw;

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] X = aov_pkg::HALF_PI_Q30 * 64'(g) / SINE_TABLE_DEPTH;
    assign rom_w[g] = aov_pkg::sine_poly(X);
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_c;
    data_r <= rom_w[idx_r];
  end

  assign data = data_r;

endmodule

FILE: src/aov_seq.sv
`timescale 1ns / 1ps

module aov_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            out_ok,
  input  aov_pkg::stat_t  stat,
  output aov_pkg::op_t    op,
  output logic            busy
);

  aov_pkg::pc_t   pc_r;
  aov_pkg::dcnt_t cnt_r;
  logic           busy_r;
  aov_pkg::uword_t word;
  logic           cond_hit;

  assign word = aov_pkg::prog_word(pc_r);

  always_comb begin
    case (word.cond)
      aov_pkg::COND_IDLE:  cond_hit = stat.gate_idle;
      aov_pkg::COND_NODIV: cond_hit = stat.no_div;
      aov_pkg::COND_LOOP:  cond_hit = (cnt_r != aov_pkg::DIV_LAST);
      default:             cond_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= aov_pkg::S_ENV;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      pc_r   <= aov_pkg::S_ENV;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (word.last) begin
        // the final step waits until the output register can take the word
        if (out_ok) begin
          busy_r <= 1'b0;
          pc_r   <= aov_pkg::S_ENV;
        end
      end else begin
        pc_r <= cond_hit ? word.target : pc_r + 1'b1;
      end
      if (word.cond == aov_pkg::COND_LOOP && cond_hit) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  assign op   = busy_r ? word.op : aov_pkg::OP_NOP;
  assign busy = busy_r;

endmodule

FILE: src/aov_dpath.sv
`timescale 1ns / 1ps

module aov_dpath #(
  parameter int TIME_BITS = aov_pkg::TIME_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  aov_pkg::cfg_t  cfg,
  input  aov_pkg::in_t   item,
  input  logic           key_on,
  input  logic           key_off,
  input  aov_pkg::op_t   op,
  input  logic           out_ok,
  input  logic [15:0]    sine_data,
  output logic [31:0]    phase,
  output aov_pkg::stat_t stat,
  output logic           res_fire,
  output aov_pkg::out_t  res
);

  localparam int CMP_W = (TIME_BITS > 21) ? TIME_BITS : 21;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam int LEN_W   = aov_pkg::LEN_W;
  localparam int LVL_W   = aov_pkg::LVL_W;
  localparam int MAG_W   = aov_pkg::MAG_W;
  localparam int MUL_A_W = aov_pkg::MUL_A_W;
  localparam int MUL_B_W = aov_pkg::MUL_B_W;
  localparam int SAT_W   = MAG_W - aov_pkg::MAG_SHIFT;

  // voice state
  logic [31:0]          phase_acc_r;
  logic [TIME_BITS-1:0] note_time_r;
  logic [LVL_W-1:0]     held_level_r;
  logic [1:0]           gate_mode_r;
  logic [31:0]          lfsr_r;
  logic [15:0]          voice_gain_r;
  logic [31:0]          voice_step_r;

  // working registers of one tick
  logic [MAG_W-1:0]     prod_r;
  logic [LVL_W-1:0]     env_r;
  logic [1:0]           kind_r;
  logic                 kill_r;
  logic                 clrh_r;
  logic signed [16:0]   wave_r;
  logic [LEN_W-1:0]     rem_r;
  logic [LVL_W-1:0]     quo_r;
  logic [LEN_W-1:0]     div_r;

  // envelope decode
  logic [CMP_W-1:0]   t_c, a_c, ad_c, r_c, t_minus_a, r_minus_t;
  logic [LEN_W:0]     ad_sum;
  logic [LVL_W-1:0]   s_eff;
  logic [LVL_W-1:0]   env_c;
  logic [1:0]         kind_c;
  logic               kill_c;
  logic               clrh_c;
  logic [LEN_W-1:0]   env_a;
  logic [LVL_W-1:0]   env_b;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MAG_W-1:0]   prod_c;

  // wave and divider
  logic [31:0]        lfsr_nxt;
  logic [17:0]        tri_q;
  logic [17:0]        tri_v;
  logic signed [16:0] wave_c;
  logic [16:0]        wave_abs;
  logic [LEN_W+1:0]   trial;
  logic [LEN_W:0]     shifted;
  logic [LEN_W-1:0]   divisor_c;

  // output shaping
  logic [SAT_W-1:0]   mag;
  logic [15:0]        sample_c;

  assign t_c       = CMP_W'(note_time_r);
  assign a_c       = CMP_W'(cfg.attack_len);
  assign r_c       = CMP_W'(cfg.release_len);
  assign ad_sum    = {1'b0, cfg.attack_len} + {1'b0, cfg.decay_len};
  assign ad_c      = CMP_W'(ad_sum);
  assign t_minus_a = t_c - a_c;
  assign r_minus_t = r_c - t_c;
  assign s_eff     = (cfg.sustain_level > aov_pkg::FULL_Q15) ? aov_pkg::FULL_Q15
                                                             : cfg.sustain_level;

  always_comb begin
    env_c  = '0;
    kind_c = aov_pkg::DV_NONE;
    kill_c = 1'b0;
    clrh_c = 1'b0;
    env_a  = '0;
    env_b  = '0;
    if (gate_mode_r == aov_pkg::GATE_HELD) begin
      if (t_c > ad_c) begin
        env_c = s_eff;
      end else if (t_c > a_c) begin
        if (cfg.decay_len == '0) begin
          env_c = s_eff;
        end else begin
          kind_c = aov_pkg::DV_DECAY;
          env_a  = t_minus_a[LEN_W-1:0];
          env_b  = aov_pkg::FULL_Q15 - s_eff;
        end
      end else if (cfg.attack_len == '0) begin
        env_c = aov_pkg::FULL_Q15;
      end else begin
        kind_c = aov_pkg::DV_ATTACK;
        env_a  = t_c[LEN_W-1:0];
        env_b  = aov_pkg::FULL_Q15;
      end
    end else begin
      if (t_c > r_c) begin
        kill_c = 1'b1;
        clrh_c = 1'b1;
      end else if (cfg.release_len == '0) begin
        clrh_c = 1'b1;
      end else begin
        kind_c = aov_pkg::DV_RELEASE;
        env_a  = r_minus_t[LEN_W-1:0];
        env_b  = held_level_r;
      end
    end
  end

  assign wave_abs = wave_r[16] ? 17'(-wave_r) : 17'(wave_r);

  always_comb begin
    case (op)
      aov_pkg::OP_ENV: begin
        mul_a = MUL_A_W'(env_a);
        mul_b = env_b;
      end
      aov_pkg::OP_GAIN: begin
        mul_a = aov_pkg::OUT_GAIN;
        mul_b = voice_gain_r;
      end
      aov_pkg::OP_MENV: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = env_r;
      end
      aov_pkg::OP_MWAVE: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = wave_abs[15:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = MAG_W'(mul_a) * MAG_W'(mul_b);

  assign lfsr_nxt = lfsr_r[0] ? ({1'b0, lfsr_r[31:1]} ^ aov_pkg::LFSR_MASK)
                              : {1'b0, lfsr_r[31:1]};

  assign tri_q = {1'b0, phase_acc_r[31:15]};
  assign tri_v = (phase_acc_r <= 32'h8000_0000) ? (tri_q - 18'd32768)
                                               : (18'd98304 - tri_q);

  always_comb begin
    case (cfg.wave_select)
      aov_pkg::WAVE_SINE:
        wave_c = phase_acc_r[31] ? -$signed({1'b0, sine_data}) : $signed({1'b0, sine_data});
      aov_pkg::WAVE_SQUARE:
        wave_c = phase_acc_r[31] ? 17'sd32768 : -17'sd32768;
      aov_pkg::WAVE_TRI:
        wave_c = $signed(tri_v[16:0]);
      aov_pkg::WAVE_SAW:
        wave_c = $signed({~phase_acc_r[31], ~phase_acc_r[31], phase_acc_r[30:16]});
      aov_pkg::WAVE_NOISE:
        wave_c = $signed({~lfsr_nxt[15], ~lfsr_nxt[15], lfsr_nxt[14:0]});
      default:
        wave_c = '0;
    endcase
  end

  // restoring division, one quotient bit per step
  assign shifted = {rem_r, quo_r[LVL_W-1]};
  assign trial   = {1'b0, shifted} - {2'b0, div_r};

  always_comb begin
    case (kind_r)
      aov_pkg::DV_ATTACK: divisor_c = cfg.attack_len;
      aov_pkg::DV_DECAY:  divisor_c = cfg.decay_len;
      default:            divisor_c = cfg.release_len;
    endcase
  end

  assign mag = prod_r[MAG_W-1:aov_pkg::MAG_SHIFT];

  always_comb begin
    if (wave_r[16]) begin
      sample_c = (mag >= SAT_W'(32768)) ? 16'h8000 : 16'(~mag[15:0] + 16'd1);
    end else begin
      sample_c = (mag >= SAT_W'(32767)) ? 16'h7FFF : mag[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r  <= '0;
      note_time_r  <= '0;
      held_level_r <= '0;
      gate_mode_r  <= aov_pkg::GATE_IDLE;
      lfsr_r       <= aov_pkg::LFSR_SEED;
      voice_gain_r <= aov_pkg::GAIN_RESET;
      voice_step_r <= '0;
    end else begin
      if (key_on || key_off) begin
        if (item.gain_valid) begin
          voice_gain_r <= item.note_gain;
        end
        note_time_r <= '0;
        if (key_on) begin
          voice_step_r <= item.phase_step;
          gate_mode_r  <= aov_pkg::GATE_HELD;
        end else begin
          gate_mode_r  <= aov_pkg::GATE_RELEASED;
        end
      end
      if (op == aov_pkg::OP_WAVE && cfg.wave_select == aov_pkg::WAVE_NOISE) begin
        lfsr_r <= lfsr_nxt;
      end
      if (op == aov_pkg::OP_FINISH && out_ok) begin
        phase_acc_r <= phase_acc_r + voice_step_r;
        if (note_time_r != TIME_MAX) begin
          note_time_r <= note_time_r + TIME_BITS'(1);
        end
        if (gate_mode_r == aov_pkg::GATE_HELD) begin
          held_level_r <= env_r;
        end else if (clrh_r) begin
          held_level_r <= '0;
        end
        if (kill_r) begin
          gate_mode_r <= aov_pkg::GATE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      aov_pkg::OP_ENV: begin
        prod_r <= prod_c;
        env_r  <= env_c;
        kind_r <= kind_c;
        kill_r <= kill_c;
        clrh_r <= clrh_c;
      end
      aov_pkg::OP_DLOAD: begin
        rem_r <= prod_r[aov_pkg::DIVD_W-1:LVL_W];
        quo_r <= prod_r[LVL_W-1:0];
        div_r <= divisor_c;
      end
      aov_pkg::OP_DSTEP: begin
        rem_r <= trial[LEN_W+1] ? shifted[LEN_W-1:0] : trial[LEN_W-1:0];
        quo_r <= {quo_r[LVL_W-2:0], ~trial[LEN_W+1]};
      end
      aov_pkg::OP_DFIN: begin
        env_r <= (kind_r == aov_pkg::DV_DECAY) ? (aov_pkg::FULL_Q15 - quo_r) : quo_r;
      end
      aov_pkg::OP_GAIN, aov_pkg::OP_MENV, aov_pkg::OP_MWAVE: begin
        prod_r <= prod_c;
      end
      aov_pkg::OP_WAVE: begin
        wave_r <= wave_c;
      end
      default: begin
      end
    endcase
  end

  assign phase          = phase_acc_r;
  assign stat.gate_idle = (gate_mode_r == aov_pkg::GATE_IDLE);
  assign stat.no_div    = (kind_r == aov_pkg::DV_NONE);

  assign res_fire = ((op == aov_pkg::OP_FINISH) || (op == aov_pkg::OP_IDLEOUT)) && out_ok;

  always_comb begin
    if (op == aov_pkg::OP_FINISH) begin
      res.sample      = $signed(sample_c);
      res.note_active = ~kill_r;
    end else begin
      res.sample      = '0;
      res.note_active = 1'b0;
    end
  end

endmodule

FILE: src/adsr_oscillator_voice_core.sv
`timescale 1ns / 1ps

// One synthesizer voice: oscillator (silence, sine, square, triangle, sawtooth or LFSR
// noise) shaped by a linear ADSR envelope, the note gain and a fixed output gain of 5000,
// saturated to a signed 16-bit sample. A key-on word loads the phase step (and the gain
// if gain_valid is set), clears note time and opens the gate; a key-off word starts the
// release from the last held level; each tick word gives one sample word. Key-on and
// key-off give no word. A tick on an idle voice skips the products, a tick in sustain
// (or with a zero-length segment) skips the divider, and a tick in attack, decay or
// release runs the 16-step serial divider that computes the envelope slope. The output
// register lets the next word in while a sample waits; a tick that finishes while that
// register is still full holds in its last step. The sine wave comes from a quarter-wave
// table of SINE_TABLE_DEPTH+1 entries. Configuration is written through
// cfg_we/cfg_index/cfg_wdata while idle; the block itself does not enforce this.
module adsr_oscillator_voice_core #(
  parameter int SINE_TABLE_DEPTH = aov_pkg::SINE_DEPTH_DEF,
  parameter int TIME_BITS        = aov_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  aov_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output aov_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [aov_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [aov_pkg::CFG_W-1:0]        cfg_wdata
);

  aov_pkg::cfg_t  cfg_r;
  aov_pkg::out_t  out_data_r;
  logic           out_valid_r;
  logic           out_ok;
  logic           accept;
  logic           start;
  logic           key_on;
  logic           key_off;
  logic           busy;
  aov_pkg::op_t   op;
  aov_pkg::stat_t stat;
  logic           res_fire;
  aov_pkg::out_t  res;
  logic [31:0]    phase;
  logic [15:0]    sine_data;

  assign accept  = in_valid && !busy;
  assign start   = accept && (in_data.req_type == aov_pkg::REQ_TICK);
  assign key_on  = accept && (in_data.req_type == aov_pkg::REQ_KEY_ON);
  assign key_off = accept && (in_data.req_type == aov_pkg::REQ_KEY_OFF);
  assign out_ok  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_select   <= aov_pkg::WAVE_SQUARE;
      cfg_r.attack_len    <= '0;
      cfg_r.decay_len     <= '0;
      cfg_r.sustain_level <= aov_pkg::FULL_Q15;
      cfg_r.release_len   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        aov_pkg::REG_WAVE:    cfg_r.wave_select   <= cfg_wdata[2:0];
        aov_pkg::REG_ATTACK:  cfg_r.attack_len    <= cfg_wdata[aov_pkg::LEN_W-1:0];
        aov_pkg::REG_DECAY:   cfg_r.decay_len     <= cfg_wdata[aov_pkg::LEN_W-1:0];
        aov_pkg::REG_SUSTAIN: cfg_r.sustain_level <= cfg_wdata[aov_pkg::LVL_W-1:0];
        aov_pkg::REG_RELEASE: cfg_r.release_len   <= cfg_wdata[aov_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_data_r <= res;
    end
  end

  aov_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .out_ok (out_ok),
    .stat   (stat),
    .op     (op),
    .busy   (busy)
  );

  aov_dpath #(
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item      (in_data),
    .key_on    (key_on),
    .key_off   (key_off),
    .op        (op),
    .out_ok    (out_ok),
    .sine_data (sine_data),
    .phase     (phase),
    .stat      (stat),
    .res_fire  (res_fire),
    .res       (res)
  );

  aov_sine #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine (
    .clk   (clk),
    .phase (phase),
    .data  (sine_data)
  );

  assign in_stall  = busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: test/adsr_oscillator_voice_core_tb.sv
`timescale 1ns / 1ps

module adsr_oscillator_voice_core_tb;
  import aov_pkg::*;

  localparam int SINE_DEPTH = SINE_DEPTH_DEF;
  localparam int TIME_W     = TIME_BITS_DEF;
  localparam int SETTLE_CYC = 40;
  localparam int LONG_HOLD  = 600;
  localparam int LIMIT_CYC  = 1_000_000;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_WORDS = 145;
  localparam int MAX_SHOWN  = 200;

  localparam logic [1:0]           REQ_UNUSED  = 2'd3;
  localparam logic [2:0]           WAVE_SPARE  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TOP     = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  adsr_oscillator_voice_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // voice registers as the predictor sees them
  logic [2:0]        c_wave = WAVE_SQUARE;
  logic [LEN_W-1:0]  c_atk  = '0;
  logic [LEN_W-1:0]  c_dec  = '0;
  logic [LVL_W-1:0]  c_sus  = FULL_Q15;
  logic [LEN_W-1:0]  c_rel  = '0;

  // voice state as the predictor sees it
  logic [31:0]       m_phase = '0;
  logic [TIME_W-1:0] m_time  = '0;
  logic [15:0]       m_hold  = '0;
  logic [1:0]        m_gate  = GATE_IDLE;
  logic [31:0]       m_noise = LFSR_SEED;
  logic [15:0]       m_gain  = GAIN_RESET;
  logic [31:0]       m_step  = '0;

  out_t        due_samples[$];
  out_t        want_word;
  int          mism_cnt = 0;
  int          words_sent = 0;
  int          samples_checked = 0;
  int          settings_cnt = 0;
  int          burst_left = 1;
  int unsigned cycle_cnt = 0;

  typedef struct packed {
    logic                 is_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    in_t                  word;
    logic                 typed;
    out_t                 typed_out;
  } drow_t;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= LIMIT_CYC);
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mism_cnt++;
    // keep the log bounded when something is badly broken
    if (mism_cnt <= MAX_SHOWN) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // quarter-wave sine entry i, Q15, from a Q30 taylor series
  function automatic int quarter_sine(input longint unsigned i);
    longint unsigned x, x2, term, acc, r;
    int k;
    x = HALF_PI_Q30 * i / SINE_DEPTH;
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / (2 * k * (2 * k + 1));
      acc = (k % 2) ? acc - term : acc + term;
    end
    r = (acc * 32768 + (64'd1 << 29)) >> 30;
    if (r > 32768) r = 32768;
    return int'(r);
  endfunction

  // oscillator output at phase p, steps the noise register when selected
  function automatic int wave_point(input logic [31:0] p);
    longint unsigned idx;
    int v, q;
    v = 0;
    case (c_wave)
      WAVE_SINE: begin
        idx = (64'(p[29:0]) * SINE_DEPTH) >> 30;
        if (p[30]) idx = SINE_DEPTH - idx;
        v = quarter_sine(idx);
        if (p[31]) v = -v;
      end
      WAVE_SQUARE: v = (p < 32'h8000_0000) ? -32768 : 32768;
      WAVE_TRI: begin
        q = int'(p >> 15);
        v = (p <= 32'h8000_0000) ? q - 32768 : 98304 - q;
      end
      WAVE_SAW: v = int'(p >> 16) - 32768;
      WAVE_NOISE: begin
        m_noise = m_noise[0] ? ((m_noise >> 1) ^ LFSR_MASK) : (m_noise >> 1);
        v = int'({16'd0, m_noise[15:0]}) - 32768;
      end
      default: v = 0;
    endcase
    return v;
  endfunction

  task automatic predict_voice(input in_t w, output bit gives, output out_t res);
    longint unsigned t, a, d, r, s, env, mag;
    longint sv;
    int wv, absw;
    gives = 1'b0;
    res = '0;
    if (w.req_type == REQ_KEY_ON || w.req_type == REQ_KEY_OFF) begin
      if (w.gain_valid) m_gain = w.note_gain;
      if (w.req_type == REQ_KEY_ON) begin
        m_step = w.phase_step;
        m_gate = GATE_HELD;
      end else begin
        m_gate = GATE_RELEASED;
      end
      m_time = '0;
    end else if (w.req_type == REQ_TICK) begin
      gives = 1'b1;
      if (m_gate != GATE_IDLE) begin
        t = 64'(m_time);
        a = 64'(c_atk);
        d = 64'(c_dec);
        r = 64'(c_rel);
        s = (c_sus > FULL_Q15) ? 64'(FULL_Q15) : 64'(c_sus);
        if (m_gate == GATE_HELD) begin
          if (t > a + d) env = s;
          else if (t > a) env = (d == 0) ? s : 32768 - ((32768 - s) * (t - a)) / d;
          else env = (a == 0) ? 32768 : (t * 32768) / a;
          m_hold = 16'(env);
        end else if (t > r) begin
          // release ran out: voice goes quiet and its gate closes
          m_gate = GATE_IDLE;
          m_hold = '0;
          env = 0;
        end else if (r == 0) begin
          m_hold = '0;
          env = 0;
        end else begin
          env = (64'(m_hold) * (r - t)) / r;
        end
        wv = wave_point(m_phase);
        absw = (wv < 0) ? -wv : wv;
        mag = (64'd5000 * 64'(m_gain) * env * 64'(absw)) >> 38;
        if (mag > 32768) mag = 32768;
        sv = (wv < 0) ? -longint'(mag) : longint'(mag);
        if (sv > 32767) sv = 32767;
        m_phase = m_phase + m_step;
        if (m_time != '1) m_time = m_time + 1'b1;
        res.sample = 16'(sv);
        res.note_active = (m_gate != GATE_IDLE);
      end
    end
  endtask

  // offer one word, predict on acceptance, then maybe open a gap
  task automatic send_word(input in_t w, input bit typed, input out_t typed_res);
    bit gives;
    out_t res;
    int gap;
    in_data = w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_voice(w, gives, res);
    if (gives) due_samples.push_back(typed ? typed_res : res);
    words_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
  endtask

  // wait for every outstanding sample, then let the block drain
  task automatic settle();
    in_valid = 1'b0;
    while (due_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_WAVE:    c_wave = val[2:0];
      REG_ATTACK:  c_atk = val;
      REG_DECAY:   c_dec = val;
      REG_SUSTAIN: c_sus = val[15:0];
      REG_RELEASE: c_rel = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic in_t rand_word(input logic [1:0] req);
    in_t w;
    w.req_type = req;
    w.phase_step = ($urandom_range(0, 2) == 0) ? 32'($urandom)
                                                : 32'($urandom_range(0, 32'h0800_0000));
    w.note_gain = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h03FF));
    w.gain_valid = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 20'hF_FFFF;
      2: return 20'($urandom);
      default: return 20'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic drow_t cfg_row(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    drow_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic drow_t word_row(input logic [1:0] req, input logic [31:0] step,
                                     input logic [15:0] gain, input logic gv);
    drow_t r;
    r = '0;
    r.word = '{req_type: req, phase_step: step, note_gain: gain, gain_valid: gv};
    return r;
  endfunction

  function automatic drow_t tick_row(input logic signed [15:0] smp, input logic act);
    drow_t r;
    r = word_row(REQ_TICK, '0, '0, 1'b0);
    r.typed = 1'b1;
    r.typed_out = '{sample: smp, note_active: act};
    return r;
  endfunction

  // sample word checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_samples.size() == 0) begin
        report_mismatch("sample word arrived with none expected");
      end else begin
        want_word = due_samples.pop_front();
        samples_checked++;
        if (out_data.sample !== want_word.sample) begin
          report_mismatch($sformatf("sample %0d, expected %0d",
                                    out_data.sample, want_word.sample));
        end
        if (out_data.note_active !== want_word.note_active) begin
          report_mismatch($sformatf("note_active %0b, expected %0b",
                                    out_data.note_active, want_word.note_active));
        end
      end
    end
  end

  // receiver: its own stall pattern, plus one long hold to back the block up
  initial begin : receiver
    bit held_long;
    held_long = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (!held_long && words_sent >= 400) begin
        held_long = 1'b1;
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      case ($urandom_range(0, 3))
        0: begin
          out_stall = 1'b0;
          repeat ($urandom_range(5, 80)) @(negedge clk);
        end
        1: begin
          out_stall = 1'b1;
          repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        default: begin
          repeat ($urandom_range(10, 60)) begin
            out_stall = ($urandom_range(0, 2) == 0);
            @(negedge clk);
          end
        end
      endcase
    end
  end

  initial begin : stimulus
    drow_t rows[$];
    drow_t row;
    bit prev_cfg;
    int ph, budget, n;
    in_t w;
    logic [15:0] sus;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    // idle voice, ignored request, key off while idle, zero step, saturation
    rows.push_back(tick_row(16'sd0, 1'b0));
    rows.push_back(word_row(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    rows.push_back(word_row(REQ_KEY_OFF, '0, 16'h1234, 1'b0));
    rows.push_back(tick_row(16'sd0, 1'b1));
    rows.push_back(tick_row(16'sd0, 1'b0));
    rows.push_back(word_row(REQ_KEY_ON, '0, 16'h0100, 1'b1));
    rows.push_back(tick_row(-16'sd5000, 1'b1));
    rows.push_back(word_row(REQ_KEY_ON, 32'h8000_0000, 16'hFFFF, 1'b1));
    rows.push_back(tick_row(-16'sd32768, 1'b1));
    rows.push_back(tick_row(16'sd32767, 1'b1));
    // unused wave code is silent
    rows.push_back(cfg_row(REG_WAVE, 20'(WAVE_SPARE)));
    rows.push_back(tick_row(16'sd0, 1'b1));
    // short sine note through all four segments, sustain above full
    rows.push_back(cfg_row(REG_WAVE, 20'(WAVE_SINE)));
    rows.push_back(cfg_row(REG_ATTACK, 20'd2));
    rows.push_back(cfg_row(REG_DECAY, 20'd2));
    rows.push_back(cfg_row(REG_SUSTAIN, 20'hF_FFFF));
    rows.push_back(cfg_row(REG_RELEASE, 20'd2));
    rows.push_back(cfg_row(REG_SPARE, 20'hF_FFFF));
    rows.push_back(word_row(REQ_KEY_ON, 32'h1000_0000, 16'h0180, 1'b1));
    repeat (6) rows.push_back(word_row(REQ_TICK, '0, '0, 1'b0));
    rows.push_back(word_row(REQ_KEY_OFF, '0, 16'h00FF, 1'b1));
    repeat (4) rows.push_back(word_row(REQ_TICK, '0, '0, 1'b0));
    // noise with the longest segments and zero sustain
    rows.push_back(cfg_row(REG_WAVE, 20'(WAVE_NOISE)));
    rows.push_back(cfg_row(REG_ATTACK, 20'hF_FFFF));
    rows.push_back(cfg_row(REG_DECAY, 20'hF_FFFF));
    rows.push_back(cfg_row(REG_SUSTAIN, 20'h0_0000));
    rows.push_back(cfg_row(REG_RELEASE, 20'hF_FFFF));
    rows.push_back(word_row(REQ_KEY_ON, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
    repeat (2) rows.push_back(word_row(REQ_TICK, '0, '0, 1'b0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    settings_cnt = 1;

    prev_cfg = 1'b0;
    foreach (rows[i]) begin
      row = rows[i];
      if (row.is_cfg) begin
        if (!prev_cfg) begin
          settle();
          settings_cnt++;
        end
        write_reg(row.idx, row.val);
      end else begin
        cfg_we = 1'b0;
        send_word(row.word, row.typed, row.typed_out);
      end
      prev_cfg = row.is_cfg;
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      settings_cnt++;
      // first phases walk every wave code; the first two pin the length extremes
      write_reg(REG_WAVE, {17'($urandom),
                           (ph < 8) ? 3'((ph + 1) % 8) : 3'($urandom_range(WAVE_SINE, WAVE_NOISE))});
      write_reg(REG_ATTACK, (ph == 0) ? '0 : (ph == 1) ? 20'hF_FFFF : pick_len());
      write_reg(REG_DECAY, (ph == 0) ? '0 : (ph == 1) ? 20'hF_FFFF : pick_len());
      write_reg(REG_RELEASE, (ph == 0) ? '0 : (ph == 1) ? 20'hF_FFFF : pick_len());
      case ($urandom_range(0, 3))
        0: sus = '0;
        1: sus = FULL_Q15;
        2: sus = 16'hFFFF;
        default: sus = 16'($urandom);
      endcase
      if (ph == 0) sus = FULL_Q15;
      if (ph == 1) sus = '0;
      write_reg(REG_SUSTAIN, {4'($urandom), sus});
      if ($urandom_range(0, 1)) begin
        write_reg(3'($urandom_range(REG_SPARE, REG_TOP)), 20'($urandom));
      end
      cfg_we = 1'b0;

      budget = 0;
      while (budget < PHASE_WORDS) begin
        if ($urandom_range(0, 7) == 0) begin
          // stray words in any order, ignored requests among them
          repeat ($urandom_range(1, 4)) begin
            w = rand_word(2'($urandom_range(0, 3)));
            send_word(w, 1'b0, '0);
            if (w.req_type != REQ_UNUSED) budget++;
          end
        end else begin
          w = rand_word(REQ_KEY_ON);
          if ($urandom_range(0, 7) == 0) w.phase_step = '0;
          send_word(w, 1'b0, '0);
          budget++;
          n = $urandom_range(0, 30);
          repeat (n) send_word(rand_word(REQ_TICK), 1'b0, '0);
          budget += n;
          if ($urandom_range(0, 5) != 0) begin
            send_word(rand_word(REQ_KEY_OFF), 1'b0, '0);
            n = $urandom_range(0, 20);
            repeat (n) send_word(rand_word(REQ_TICK), 1'b0, '0);
            budget += n + 1;
          end
        end
      end
    end

    settle();
    $display("covered %0d input words across %0d register settings, all wave codes,",
             words_sent, settings_cnt);
    $display("envelope segments and a long output hold; %0d sample words checked",
             samples_checked);
    if (mism_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
src/aov_pkg.sv
src/aov_sine.sv
src/aov_seq.sv
src/aov_dpath.sv
src/adsr_oscillator_voice_core.sv
test/adsr_oscillator_voice_core_tb.sv
